[rtl/core/bfht_pkg.sv]
// Shared types and constants of the best-fit hole table.
package bfht_pkg;

	localparam int unsigned MAX_HOLES    = 64;
	localparam int unsigned HEADER_BYTES = 16;
	localparam int unsigned IDX_W        = $clog2(MAX_HOLES);
	localparam int unsigned CNT_W        = $clog2(MAX_HOLES + 1);

	// Configuration register indexes
	localparam logic [1:0] REG_HEAP_CAPACITY = 2'd0;
	localparam logic [1:0] REG_HEAP_START    = 2'd1;
	localparam logic [1:0] REG_HEAP_END      = 2'd2;

	// Request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_FIT  = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;
	localparam logic [1:0] STAT_OUTSIDE = 2'd3;

	// Search token that walks the cell chain, one cell per cycle
	typedef struct packed {
		logic             vld;
		logic             found;
		logic             done;
		logic [31:0]      req_size;
		logic [IDX_W-1:0] best_idx;
		logic [31:0]      fit_bytes;
		logic [31:0]      best_start;
	} tok_t;

	// Table update command broadcast to every cell
	typedef struct packed {
		logic             shift;
		logic [IDX_W-1:0] shift_pos;
		logic             append;
		logic [31:0]      app_start;
		logic [31:0]      app_bytes;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

[rtl/core/bfht_cell.sv]
// One table cell: holds a hole entry and advances the search token by one place.
module bfht_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfht_pkg::IDX_W-1:0] cell_idx,
	input  bfht_pkg::cell_ctrl_t      ctrl,
	input  logic [31:0]               nxt_start,
	input  logic [31:0]               nxt_bytes,
	input  bfht_pkg::tok_t            tok_in,
	output bfht_pkg::tok_t            tok_out,
	output logic [31:0]               ent_start,
	output logic [31:0]               ent_bytes
);

	logic [31:0]    start_q;
	logic [31:0]    bytes_q;
	bfht_pkg::tok_t tok_q;
	bfht_pkg::tok_t tok_nxt;
	logic           in_use;

	assign in_use = {1'b0, cell_idx} < ctrl.count;

	// Fold this entry into the running best fit
	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.vld && !tok_in.done && in_use && (bytes_q >= tok_in.req_size)) begin
			if (bytes_q == tok_in.req_size) begin
				tok_nxt.found      = 1'b1;
				tok_nxt.done       = 1'b1;
				tok_nxt.best_idx   = cell_idx;
				tok_nxt.fit_bytes  = bytes_q;
				tok_nxt.best_start = start_q;
			end else if (!tok_in.found || (bytes_q < tok_in.fit_bytes)) begin
				tok_nxt.found      = 1'b1;
				tok_nxt.best_idx   = cell_idx;
				tok_nxt.fit_bytes  = bytes_q;
				tok_nxt.best_start = start_q;
			end
		end
	end

	// Token register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Entry: take the neighbor on removal, take new data on append
	always_ff @(posedge clk) begin
		if (ctrl.shift && (cell_idx >= ctrl.shift_pos)) begin
			start_q <= nxt_start;
			bytes_q <= nxt_bytes;
		end else if (ctrl.append && (cell_idx == ctrl.count[bfht_pkg::IDX_W-1:0])) begin
			start_q <= ctrl.app_start;
			bytes_q <= ctrl.app_bytes;
		end
	end

	assign tok_out   = tok_q;
	assign ent_start = start_q;
	assign ent_bytes = bytes_q;

endmodule

[rtl/core/best_fit_hole_table.sv]
// Top level of the best-fit hole table: control, configuration and the cell chain.
//
// Usage:
//   s_* channel takes one request per transaction: s_tuser is the kind
//   (0 allocate, 1 free), s_tdata carries req_size, block_addr, block_size.
//   m_* channel returns one result per request: ok, grant_addr, status.
//   cfg_* channel writes heap_capacity (0), heap_start (1), heap_end (2);
//   other indexes are ignored. cfg_ready is always high.
// Sequencing:
//   A free, or an allocate larger than heap_capacity, goes to S_FINISH and
//   then loads the output register once it is free. An allocate that searches
//   sends a token through the 64-cell chain, one cell per cycle, then, if a
//   hole fits, removes it by shifting every later cell down at once. One
//   request is worked on at a time; the next is accepted once the current
//   result sits in the output register.
// Reset: empties the table (count zero) and clears the configuration.
// Stall: the result holds in the output register while m_tready is low; a
//   new request may be accepted meanwhile, and its result waits until the
//   output register drains.
module best_fit_hole_table (
	input  logic        clk,
	input  logic        arst_n,
	// Request: [31:0] req_size, [63:32] block_addr, [95:64] block_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,
	// Request kind: [0] action
	input  logic        s_tuser,
	// Result: [0] ok, [32:1] grant_addr, [34:33] status, [39:35] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,
	// Configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                     state_q;
	logic [31:0]                heap_capacity_q;
	logic [31:0]                heap_start_q;
	logic [31:0]                heap_end_q;
	logic [bfht_pkg::CNT_W-1:0] count_q;
	logic                       res_ok_q;
	logic [31:0]                res_addr_q;
	logic [1:0]                 res_status_q;
	logic                       out_vld_q;
	logic [39:0]                out_data_q;

	logic [31:0]          req_size;
	logic [31:0]          block_addr;
	logic [31:0]          block_size;
	logic                 in_acc;
	logic                 inside_heap;
	logic                 has_room;
	logic                 fits_cap;
	logic                 out_free;
	bfht_pkg::cell_ctrl_t ctrl;
	bfht_pkg::tok_t       tok [bfht_pkg::MAX_HOLES+1];
	logic [31:0]          ent_start [bfht_pkg::MAX_HOLES];
	logic [31:0]          ent_bytes [bfht_pkg::MAX_HOLES];
	bfht_pkg::tok_t       tok_end;

	assign req_size    = s_tdata[31:0];
	assign block_addr  = s_tdata[63:32];
	assign block_size  = s_tdata[95:64];
	assign s_tready    = (state_q == S_IDLE);
	assign in_acc      = s_tvalid && s_tready;
	assign inside_heap = (block_addr < heap_end_q) && (block_addr > heap_start_q);
	assign has_room    = count_q < bfht_pkg::CNT_W'(bfht_pkg::MAX_HOLES);
	assign fits_cap    = heap_capacity_q >= req_size;
	assign out_free    = !out_vld_q || m_tready;
	assign tok_end     = tok[bfht_pkg::MAX_HOLES];
	assign cfg_ready   = 1'b1;

	// Search token launched into the first cell on an allocate within capacity
	always_comb begin
		tok[0]            = '0;
		tok[0].vld        = in_acc && (s_tuser == bfht_pkg::ACT_ALLOC) && fits_cap;
		tok[0].req_size   = req_size;
	end

	// Table update commands
	always_comb begin
		ctrl           = '0;
		ctrl.count     = count_q;
		ctrl.shift     = (state_q == S_SCAN) && tok_end.vld && tok_end.found;
		ctrl.shift_pos = tok_end.best_idx;
		ctrl.append    = in_acc && (s_tuser == bfht_pkg::ACT_FREE) && inside_heap && has_room;
		ctrl.app_start = block_addr - 32'(bfht_pkg::HEADER_BYTES);
		ctrl.app_bytes = block_size;
	end

	// Cell chain
	for (genvar g = 0; g < bfht_pkg::MAX_HOLES; g++) begin : g_cell
		logic [31:0] nxt_start;
		logic [31:0] nxt_bytes;
		if (g == bfht_pkg::MAX_HOLES - 1) begin : g_last
			assign nxt_start = ent_start[g];
			assign nxt_bytes = ent_bytes[g];
		end else begin : g_mid
			assign nxt_start = ent_start[g+1];
			assign nxt_bytes = ent_bytes[g+1];
		end
		bfht_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (bfht_pkg::IDX_W'(g)),
			.ctrl      (ctrl),
			.nxt_start (nxt_start),
			.nxt_bytes (nxt_bytes),
			.tok_in    (tok[g]),
			.tok_out   (tok[g+1]),
			.ent_start (ent_start[g]),
			.ent_bytes (ent_bytes[g])
		);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_capacity_q <= '0;
			heap_start_q    <= '0;
			heap_end_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bfht_pkg::REG_HEAP_CAPACITY: heap_capacity_q <= cfg_data;
				bfht_pkg::REG_HEAP_START:    heap_start_q    <= cfg_data;
				bfht_pkg::REG_HEAP_END:      heap_end_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hole count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.append) begin
			count_q <= count_q + bfht_pkg::CNT_W'(1);
		end else if (ctrl.shift) begin
			count_q <= count_q - bfht_pkg::CNT_W'(1);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= tok[0].vld ? S_SCAN : S_FINISH;
					end
				end
				S_SCAN: begin
					if (tok_end.vld) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_ok_q     <= 1'b0;
			res_addr_q   <= '0;
			res_status_q <= bfht_pkg::STAT_NO_FIT;
			if (s_tuser == bfht_pkg::ACT_FREE) begin
				if (!inside_heap) begin
					res_status_q <= bfht_pkg::STAT_OUTSIDE;
				end else if (!has_room) begin
					res_status_q <= bfht_pkg::STAT_FULL;
				end else begin
					res_ok_q     <= 1'b1;
					res_status_q <= bfht_pkg::STAT_OK;
				end
			end
		end else if (ctrl.shift) begin
			res_ok_q     <= 1'b1;
			res_addr_q   <= tok_end.best_start + 32'(bfht_pkg::HEADER_BYTES);
			res_status_q <= bfht_pkg::STAT_OK;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if ((state_q == S_FINISH) && out_free) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			out_data_q <= {5'b0, res_status_q, res_addr_q, res_ok_q};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

[bench/best_fit_hole_table_tb.sv]
// Testbench for best_fit_hole_table: directed and random alloc/free traffic checked against a
// behavioral model of the hole table.
`timescale 1ns / 1ps

module best_fit_hole_table_tb;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned HOLD_CYCLES = 500;
	localparam int unsigned SETTLE_CYCLES = 70;
	// unmapped register index, the block ignores writes to it
	localparam logic [1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic        ok;
		logic [31:0] addr;
		logic [1:0]  status;
	} grant_t;

	// One line of the directed script: a register write or a request
	typedef struct {
		logic        is_cfg;
		logic [1:0]  reg_idx;
		logic        act;
		logic [31:0] req;
		logic [31:0] baddr;
		logic [31:0] bsize;
		logic        typed;
		grant_t      want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // [31:0] req_size, [63:32] block_addr, [95:64] block_size
	logic        s_tuser = 1'b0; // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // [0] ok, [32:1] grant_addr, [34:33] status, [39:35] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Model of the hole table and its configuration
	logic [31:0] hole_at [bfht_pkg::MAX_HOLES];
	logic [31:0] hole_len [bfht_pkg::MAX_HOLES];
	int unsigned holes_used = 0;
	logic [31:0] heap_cap = '0;
	logic [31:0] heap_lo = '0;
	logic [31:0] heap_hi = '0;

	grant_t pending_grants[$];
	int     mismatches = 0;
	int     cycle_count = 0;
	logic   no_idle = 1'b0;
	int     hold_asks = 0;
	int     hold_done = 0;

	best_fit_hole_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Applies one request to the table model and returns the grant it yields
	function automatic grant_t apply_request(logic act, logic [31:0] req, logic [31:0] baddr,
			logic [31:0] bsize);
		grant_t      g;
		logic        found;
		int unsigned best;
		logic [31:0] best_len;
		g = '{ok: 1'b0, addr: 32'd0, status: bfht_pkg::STAT_NO_FIT};
		found = 1'b0;
		best = 0;
		best_len = '0;
		if (act == bfht_pkg::ACT_ALLOC) begin
			if (heap_cap >= req) begin
				for (int unsigned i = 0; i < holes_used; i++) begin
					if (hole_len[i] >= req) begin
						// exact fit ends the search
						if (hole_len[i] == req) begin
							found = 1'b1;
							best = i;
							break;
						end
						if (!found || hole_len[i] < best_len) begin
							found = 1'b1;
							best = i;
							best_len = hole_len[i];
						end
					end
				end
				if (found) begin
					g.addr = hole_at[best] + 32'(bfht_pkg::HEADER_BYTES);
					for (int unsigned k = best + 1; k < holes_used; k++) begin
						hole_at[k-1] = hole_at[k];
						hole_len[k-1] = hole_len[k];
					end
					holes_used--;
					g.ok = 1'b1;
					g.status = bfht_pkg::STAT_OK;
				end
			end
		end else if (baddr < heap_hi && baddr > heap_lo) begin
			if (holes_used < bfht_pkg::MAX_HOLES) begin
				hole_at[holes_used] = baddr - 32'(bfht_pkg::HEADER_BYTES);
				hole_len[holes_used] = bsize;
				holes_used++;
				g.ok = 1'b1;
				g.status = bfht_pkg::STAT_OK;
			end else begin
				g.status = bfht_pkg::STAT_FULL;
			end
		end else begin
			g.status = bfht_pkg::STAT_OUTSIDE;
		end
		return g;
	endfunction

	function automatic script_row_t op_row(logic act, logic [31:0] req, logic [31:0] baddr,
			logic [31:0] bsize, logic typed = 1'b0, grant_t want = '0);
		script_row_t r;
		r = '{is_cfg: 1'b0, reg_idx: 2'd0, act: act, req: req, baddr: baddr, bsize: bsize,
			typed: typed, want: want};
		return r;
	endfunction

	function automatic script_row_t reg_row(logic [1:0] idx, logic [31:0] data);
		script_row_t r;
		r = '{is_cfg: 1'b1, reg_idx: idx, act: 1'b0, req: data, baddr: '0, bsize: '0,
			typed: 1'b0, want: '0};
		return r;
	endfunction

	// Offers one request after a random gap and records its grant on acceptance
	task automatic send_request(input logic act, input logic [31:0] req, input logic [31:0] baddr,
			input logic [31:0] bsize, input logic typed, input grant_t want);
		int     gap;
		grant_t g;
		gap = no_idle ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {bsize, baddr, req};
		do @(posedge clk); while (!(s_tvalid && s_tready));
		g = apply_request(act, req, baddr, bsize);
		pending_grants.push_back(typed ? want : g);
	endtask

	// Stops offering and waits until every outstanding grant has come back
	task automatic drain_results();
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		while (pending_grants.size() != 0) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write of a group
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			bfht_pkg::REG_HEAP_CAPACITY: heap_cap = data;
			bfht_pkg::REG_HEAP_START:    heap_lo = data;
			bfht_pkg::REG_HEAP_END:      heap_hi = data;
			default: ;
		endcase
	endtask

	task automatic set_heap(input logic [31:0] cap, input logic [31:0] lo, input logic [31:0] hi);
		drain_results();
		write_reg(bfht_pkg::REG_HEAP_CAPACITY, cap);
		write_reg(bfht_pkg::REG_HEAP_START, lo);
		write_reg(bfht_pkg::REG_HEAP_END, hi);
		write_reg(REG_SPARE, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed traffic: frees inside the heap, allocs sized from stored holes
	task automatic make_item(input int free_pct, output logic act, output logic [31:0] req,
			output logic [31:0] baddr, output logic [31:0] bsize);
		logic [31:0] span;
		int unsigned pick;
		act = bfht_pkg::ACT_ALLOC;
		req = $urandom_range(0, 255);
		baddr = $urandom;
		bsize = $urandom;
		pick = (holes_used > 0) ? $urandom_range(0, holes_used - 1) : 0;
		if ($urandom_range(0, 99) < 6) begin
			act = 1'($urandom_range(0, 1));
			req = $urandom;
		end else if ($urandom_range(0, 99) < free_pct) begin
			act = bfht_pkg::ACT_FREE;
			case ($urandom_range(0, 5))
				0, 1, 2: bsize = 16 * $urandom_range(1, 8);
				3:       bsize = $urandom_range(0, 255);
				4:       bsize = $urandom;
				default: bsize = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			endcase
			case ($urandom_range(0, 19))
				0: baddr = heap_lo;
				1: baddr = heap_hi;
				2: baddr = $urandom;
				default: begin
					if (heap_hi > heap_lo && heap_hi - heap_lo > 1) begin
						span = heap_hi - heap_lo - 1;
						baddr = heap_lo + 1 + ($urandom % span);
					end
				end
			endcase
		end else begin
			case ($urandom_range(0, 5))
				0, 1: if (holes_used > 0) req = hole_len[pick];
				2: begin
					if (holes_used > 0)
						req = hole_len[pick] - (hole_len[pick] > 20 ? $urandom_range(1, 20) : 0);
				end
				3:       req = 16 * $urandom_range(0, 8);
				4:       req = $urandom;
				default: req = heap_cap + $urandom_range(0, 2);
			endcase
		end
	endtask

	task automatic run_phase(input int n, input int free_pct);
		logic        act;
		logic [31:0] req, baddr, bsize;
		for (int k = 0; k < n; k++) begin
			// second quarter of each phase runs back to back
			no_idle = (k >= n / 4) && (k < n / 2);
			if (k > 0 && k % 100 == 0)
				drain_results();
			make_item(free_pct, act, req, baddr, bsize);
			send_request(act, req, baddr, bsize, 1'b0, '0);
		end
		no_idle = 1'b0;
	endtask

	// Result side backpressure, with one long hold-off on request
	initial begin
		int w;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_asks != hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done++;
			end else begin
				w = no_idle ? 0 : $urandom_range(0, 13);
				if (w > 0) begin
					m_tready <= 1'b0;
					repeat (w) @(posedge clk);
				end
				m_tready <= 1'b1;
				do @(posedge clk); while (!(m_tvalid && m_tready) && hold_asks == hold_done);
			end
		end
	end

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		grant_t exp_g;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_grants.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with nothing pending, data %h", $time, m_tdata);
			end else begin
				exp_g = pending_grants.pop_front();
				compare_field("ok", 32'(exp_g.ok), 32'(m_tdata[0]));
				compare_field("grant_addr", exp_g.addr, m_tdata[32:1]);
				compare_field("status", 32'(exp_g.status), 32'(m_tdata[34:33]));
			end
		end
	end

	// Stimulus
	initial begin
		script_row_t script[$];
		logic [31:0] lo;

		// reset state: capacity, start and end all zero
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd0, 32'd0, 32'd0, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_NO_FIT}));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'd100, 32'd8, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_OUTSIDE}));
		script.push_back(reg_row(bfht_pkg::REG_HEAP_CAPACITY, 32'hFFFF_FFFF));
		script.push_back(reg_row(bfht_pkg::REG_HEAP_START, 32'h0));
		script.push_back(reg_row(bfht_pkg::REG_HEAP_END, 32'hFFFF_FFFF));
		script.push_back(reg_row(REG_SPARE, 32'h1234_5678));
		// heap bounds are exclusive
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h0, 32'd64, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_OUTSIDE}));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'hFFFF_FFFF, 32'd64, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_OUTSIDE}));
		// hole address wraps below zero, data address wraps back
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h1, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd0, 32'd0, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
			32'hFFFF_FFFF));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		// equal sizes: earliest wins; otherwise smallest that fits
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h1000, 32'd100));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h2000, 32'd100));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h3000, 32'd200));
		script.push_back(op_row(bfht_pkg::ACT_FREE, 32'd0, 32'h4000, 32'd120));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd90, 32'd0, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd110, 32'd0, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd300, 32'd0, 32'd0, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_NO_FIT}));
		// request above capacity fails although a hole would fit
		script.push_back(reg_row(bfht_pkg::REG_HEAP_CAPACITY, 32'd150));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd200, 32'd0, 32'd0, 1'b1,
			'{1'b0, 32'd0, bfht_pkg::STAT_NO_FIT}));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd150, 32'd0, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd100, 32'd0, 32'd0));
		script.push_back(op_row(bfht_pkg::ACT_ALLOC, 32'd1, 32'd0, 32'd0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < script.size(); i++) begin
			if (script[i].is_cfg) begin
				if (i == 0 || !script[i-1].is_cfg)
					drain_results();
				write_reg(script[i].reg_idx, script[i].req);
				if (i + 1 == script.size() || !script[i+1].is_cfg)
					cfg_valid <= 1'b0;
			end else begin
				send_request(script[i].act, script[i].req, script[i].baddr, script[i].bsize,
					script[i].typed, script[i].want);
			end
		end

		// random phases
		set_heap(32'hFFFF_FFFF, 32'h0000_1000, 32'h0010_0000);
		run_phase(350, 55);
		set_heap(32'h0000_0800, 32'h0, 32'hFFFF_FFFF);
		run_phase(250, 50);
		// fill the table while the result side stalls
		set_heap(32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF);
		hold_asks++;
		run_phase(120, 90);
		run_phase(150, 35);
		set_heap(32'h0, 32'hFFFF_FFFF, 32'h0);
		run_phase(80, 50);
		lo = $urandom_range(0, 32'h7FFF_FFFF);
		set_heap($urandom, lo, lo + $urandom_range(2, 32'h0FFF_FFFF));
		run_phase(150, 50);
		lo = $urandom_range(0, 32'h7FFF_FFFF);
		set_heap($urandom_range(0, 200), lo, lo + $urandom_range(2, 32'h0000_FFFF));
		run_phase(150, 50);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_grants.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
